@@ rtl/core/rolling_hash_substring_counter_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the rolling hash substring counter
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_COUNTER_UNIT_ASSERT_SVH
`define ROLLING_HASH_SUBSTRING_COUNTER_UNIT_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define RHSC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define RHSC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RHSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/rhsc_pkg.sv @@
// ---------------------------------------------------------------------------
// Rolling hash substring counter package
// Field widths, moduli, register indexes, stage structs and the constant
// folding tables used to keep the rolling hashes in a bounded redundant form.
// ---------------------------------------------------------------------------
`default_nettype none

package rhsc_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 11;
	localparam int HASH_W     = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;
	localparam int TOTAL_W    = 20;
	localparam int PROD_W     = BYTE_W + HASH_W;
	localparam int RED_W      = 32;
	localparam int ROLL_W     = 41;
	localparam int FOLD_N     = 16;
	localparam int RED_SPAN   = 5;

	localparam logic [HASH_W-1:0] MOD_A     = 30'd1000000007;
	localparam logic [HASH_W-1:0] MOD_B     = 30'd1000000009;
	localparam logic [HASH_W-1:0] HASH_BASE = 30'd347;
	localparam logic [RED_W-1:0]  MOD_A_X4  = {MOD_A, 2'b00};
	localparam logic [RED_W-1:0]  MOD_B_X4  = {MOD_B, 2'b00};

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HASH_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HASH_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WEIGHT_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WEIGHT_B = 3'd4;

	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1;

	typedef logic [FOLD_N-1:0][HASH_W-1:0] fold_tbl_t;

	// Byte entering stage two, with the byte leaving the window.
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] text_byte;
		logic [BYTE_W-1:0] drop;
		logic              removing;
		logic              last;
		logic              full;
	} rhsc_item_t;

	// Hash comparison leaving the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
		logic match;
	} rhsc_match_t;

	// Entry i holds (i * 2^shift) mod the selected modulus.
	function automatic fold_tbl_t make_fold(int unsigned shift, logic use_b);
		fold_tbl_t   tbl;
		logic [63:0] x;
		for (int i = 0; i < FOLD_N; i++) begin
			x = 64'(i) << shift;
			if (use_b) begin
				tbl[i] = HASH_W'(x % 64'(MOD_B));
			end else begin
				tbl[i] = HASH_W'(x % 64'(MOD_A));
			end
		end
		return tbl;
	endfunction

	localparam fold_tbl_t FOLD_A0 = make_fold(30, 1'b0);
	localparam fold_tbl_t FOLD_A1 = make_fold(34, 1'b0);
	localparam fold_tbl_t FOLD_A2 = make_fold(38, 1'b0);
	localparam fold_tbl_t FOLD_B0 = make_fold(30, 1'b1);
	localparam fold_tbl_t FOLD_B1 = make_fold(34, 1'b1);
	localparam fold_tbl_t FOLD_B2 = make_fold(38, 1'b1);

	// Replaces the bits above 2^30 by their residues. The result is congruent
	// to t and stays below 2^30 + 3 * modulus, which fits in 32 bits.
	function automatic logic [RED_W-1:0] fold_red(logic [ROLL_W-1:0] t, fold_tbl_t t0,
			fold_tbl_t t1, fold_tbl_t t2);
		return RED_W'(t[HASH_W-1:0]) + RED_W'(t0[t[33:30]]) + RED_W'(t1[t[37:34]])
			+ RED_W'(t2[{1'b0, t[40:38]}]);
	endfunction

	// True when the redundant hash h reduces to p. h is below 5 * m, so the
	// candidates are p plus a small multiple of m.
	function automatic logic hash_eq(logic [RED_W-1:0] h, logic [HASH_W-1:0] p,
			logic [HASH_W-1:0] m);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < RED_SPAN; k++) begin
			hit = hit | ({1'b0, h} == (33'(p) + 33'(k) * 33'(m)));
		end
		return (p < m) && hit;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rhsc_if.sv @@
// ---------------------------------------------------------------------------
// Rolling hash substring counter channels
// Valid/ready channels for text bytes in and match results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface rhsc_text_if;
	import rhsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface rhsc_result_if;
	import rhsc_pkg::*;

	logic               valid;
	logic               ready;
	logic               window_match;
	logic [TOTAL_W-1:0] match_total;
	logic               text_done;

	modport source (output valid, window_match, match_total, text_done, input ready);
	modport sink (input valid, window_match, match_total, text_done, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rhsc_hash_pipe.sv @@
// ---------------------------------------------------------------------------
// Rolling hash pipeline
// Weighs the leaving byte, folds it into an addend and updates both rolling
// hashes once per byte, then compares them with the pattern hashes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rolling_hash_substring_counter_unit_assert.svh"

module rhsc_hash_pipe (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire rhsc_pkg::rhsc_item_t        item,
	output logic                             ready,
	input  wire [rhsc_pkg::HASH_W-1:0]       weight_a,
	input  wire [rhsc_pkg::HASH_W-1:0]       weight_b,
	input  wire [rhsc_pkg::HASH_W-1:0]       pattern_a,
	input  wire [rhsc_pkg::HASH_W-1:0]       pattern_b,
	output rhsc_pkg::rhsc_match_t            res,
	input  wire                              take
);
	import rhsc_pkg::*;

	localparam logic [RED_W:0] HASH_LIMIT_A = 33'(1 << HASH_W) + 33'(3) * 33'(MOD_A);
	localparam logic [RED_W:0] HASH_LIMIT_B = 33'(1 << HASH_W) + 33'(3) * 33'(MOD_B);
	localparam logic [RED_W:0] ADD_LIMIT_A  = 33'(MOD_A_X4) + 33'(1 << BYTE_W);

	logic free_s2, free_s3, free_s4;
	logic load_s4;

	logic              v_s2;
	logic [PROD_W-1:0] prod_a_s2, prod_b_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic              last_s2, full_s2;

	logic             v_s3;
	logic [RED_W-1:0] c_a_s3, c_b_s3;
	logic             last_s3, full_s3;

	logic             v_s4;
	logic [RED_W-1:0] hash_a_s4, hash_b_s4;
	logic             last_s4, full_s4;

	logic [RED_W-1:0] hash_a_q, hash_b_q;

	logic [BYTE_W-1:0] drop_eff;
	logic [RED_W-1:0]  c_a, c_b;
	logic [ROLL_W-1:0] roll_a, roll_b;
	logic [RED_W-1:0]  next_a, next_b;

	assign free_s4 = !v_s4 || take;
	assign free_s3 = !v_s3 || free_s4;
	assign free_s2 = !v_s2 || free_s3;
	assign ready   = free_s2;
	assign load_s4 = v_s3 && free_s4;

	// The ring entry is only meaningful once the window is full.
	assign drop_eff = item.removing ? item.drop : '0;

	// Addend for the recurrence: byte minus the weighted leaving byte, kept
	// positive by adding four times the modulus.
	assign c_a = MOD_A_X4 - fold_red(ROLL_W'(prod_a_s2), FOLD_A0, FOLD_A1, FOLD_A2)
		+ RED_W'(byte_s2);
	assign c_b = MOD_B_X4 - fold_red(ROLL_W'(prod_b_s2), FOLD_B0, FOLD_B1, FOLD_B2)
		+ RED_W'(byte_s2);

	assign roll_a = ROLL_W'(hash_a_q) * ROLL_W'(HASH_BASE) + ROLL_W'(c_a_s3);
	assign roll_b = ROLL_W'(hash_b_q) * ROLL_W'(HASH_BASE) + ROLL_W'(c_b_s3);
	assign next_a = fold_red(roll_a, FOLD_A0, FOLD_A1, FOLD_A2);
	assign next_b = fold_red(roll_b, FOLD_B0, FOLD_B1, FOLD_B2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			hash_a_q <= '0;
			hash_b_q <= '0;
		end else begin
			if (free_s2) v_s2 <= item.valid;
			if (free_s3) v_s3 <= v_s2;
			if (free_s4) v_s4 <= v_s3;
			if (load_s4) begin
				hash_a_q <= last_s3 ? '0 : next_a;
				hash_b_q <= last_s3 ? '0 : next_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && free_s2) begin
			prod_a_s2 <= {{HASH_W{1'b0}}, drop_eff} * {{BYTE_W{1'b0}}, weight_a};
			prod_b_s2 <= {{HASH_W{1'b0}}, drop_eff} * {{BYTE_W{1'b0}}, weight_b};
			byte_s2   <= item.text_byte;
			last_s2   <= item.last;
			full_s2   <= item.full;
		end
		if (v_s2 && free_s3) begin
			c_a_s3  <= c_a;
			c_b_s3  <= c_b;
			last_s3 <= last_s2;
			full_s3 <= full_s2;
		end
		if (load_s4) begin
			hash_a_s4 <= next_a;
			hash_b_s4 <= next_b;
			last_s4   <= last_s3;
			full_s4   <= full_s3;
		end
	end

	always_comb begin
		res.valid = v_s4;
		res.last  = last_s4;
		res.match = full_s4 && hash_eq(hash_a_s4, pattern_a, MOD_A)
			&& hash_eq(hash_b_s4, pattern_b, MOD_B);
	end

	`RHSC_ASSERT_ALWAYS(a_hash_bounded, ({1'b0, hash_a_q} < HASH_LIMIT_A) && ({1'b0, hash_b_q} < HASH_LIMIT_B), "rolling hash left its redundant range")
	`RHSC_ASSERT_NEXT(a_hash_cleared, load_s4 && last_s3, (hash_a_q == '0) && (hash_b_q == '0), "rolling hash not cleared after the last byte")
	`RHSC_ASSERT_IMPLY(a_addend_bounded, v_s3, {1'b0, c_a_s3} < ADD_LIMIT_A, "recurrence addend out of range")

endmodule

`default_nettype wire

@@ rtl/core/rolling_hash_substring_counter_unit.sv @@
// ---------------------------------------------------------------------------
// Rolling hash substring counter
// Counts windows of a byte stream whose double polynomial hash (base 347,
// moduli 1000000007 and 1000000009) equals a configured pattern hash pair.
// ---------------------------------------------------------------------------
//  Channel   Role  Payload                                    Transfer
//  text      in    text_byte[7:0], end_of_text                valid & ready
//  result    out   window_match, match_total[19:0], text_done valid & ready
//  cfg       in    cfg_index[2:0], cfg_data[29:0]             cfg_write
//
// One byte per cycle sustained while result.ready does not stall the output.
// The rate is set by the hash recurrence in stage three. Five bytes can be
// in flight, so the input keeps taking bytes while a result waits. The ring
// memory is not cleared by reset and needs no clearing pass; reset clears
// the hashes, counters and pointers at once.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rolling_hash_substring_counter_unit_assert.svh"

module rolling_hash_substring_counter_unit #(
	parameter int MAX_PATTERN = 1024,
	parameter int COUNT_BITS  = 20
) (
	input  wire                                clk,
	input  wire                                arst_n,
	rhsc_text_if.sink                          text,
	rhsc_result_if.source                      result,
	input  wire                                cfg_write,
	input  wire [rhsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [rhsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rhsc_pkg::*;

	localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic [LEN_W-1:0]  len_q;
	logic [HASH_W-1:0] phash_a_q, phash_b_q, weight_a_q, weight_b_q;

	logic [CNT_W-1:0] len_eff;
	logic [PTR_W-1:0] pos_q, pos_next;
	logic [CNT_W-1:0] seen_q, seen_next;
	logic [CNT_W:0]   rd_sum, rd_wrap;
	logic [PTR_W-1:0] rd_addr;
	logic             accept;

	logic [BYTE_W-1:0] ring_mem [MAX_PATTERN];

	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1, drop_s1;
	logic              rem_s1, last_s1, full_s1;
	logic              free_s1;

	rhsc_item_t  item;
	rhsc_match_t res;
	logic        pipe_ready;

	logic                  free_out, take;
	logic                  out_valid_q, match_q, done_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [COUNT_BITS-1:0] cnt_q, cnt_new;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= LEN_RESET;
			phash_a_q  <= '0;
			phash_b_q  <= '0;
			weight_a_q <= HASH_BASE;
			weight_b_q <= HASH_BASE;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_LENGTH:  len_q      <= cfg_data[LEN_W-1:0];
				REG_PATTERN_HASH_A:  phash_a_q  <= cfg_data[HASH_W-1:0];
				REG_PATTERN_HASH_B:  phash_b_q  <= cfg_data[HASH_W-1:0];
				REG_WINDOW_WEIGHT_A: weight_a_q <= cfg_data[HASH_W-1:0];
				REG_WINDOW_WEIGHT_B: weight_b_q <= cfg_data[HASH_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero length behaves as one, and a length beyond the ring as the ring.
	always_comb begin
		if (len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (32'(len_q) > MAX_PATTERN) begin
			len_eff = CNT_W'(MAX_PATTERN);
		end else begin
			len_eff = CNT_W'(len_q);
		end
	end

	always_comb begin
		rd_sum = (CNT_W+1)'(pos_q) + (CNT_W+1)'(MAX_PATTERN) - (CNT_W+1)'(len_eff);
		if (rd_sum >= (CNT_W+1)'(MAX_PATTERN)) begin
			rd_wrap = rd_sum - (CNT_W+1)'(MAX_PATTERN);
		end else begin
			rd_wrap = rd_sum;
		end
		rd_addr   = rd_wrap[PTR_W-1:0];
		pos_next  = (pos_q == PTR_W'(MAX_PATTERN - 1)) ? '0 : pos_q + 1'b1;
		seen_next = (seen_q == CNT_W'(MAX_PATTERN)) ? seen_q : seen_q + 1'b1;
	end

	assign free_s1    = !v_s1 || pipe_ready;
	assign accept     = text.valid && free_s1;
	assign text.ready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			pos_q  <= '0;
			seen_q <= '0;
		end else begin
			if (free_s1) v_s1 <= text.valid;
			if (accept) begin
				pos_q  <= text.end_of_text ? '0 : pos_next;
				seen_q <= text.end_of_text ? '0 : seen_next;
			end
		end
	end

	// The read returns the entry as it was before this cycle's write, which
	// is the leaving byte when the window spans the whole ring.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[pos_q] <= text.text_byte;
			drop_s1         <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.end_of_text;
			rem_s1  <= seen_q >= len_eff;
			full_s1 <= seen_next >= len_eff;
		end
	end

	always_comb begin
		item.valid     = v_s1;
		item.text_byte = byte_s1;
		item.drop      = drop_s1;
		item.removing  = rem_s1;
		item.last      = last_s1;
		item.full      = full_s1;
	end

	rhsc_hash_pipe u_hash_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ready     (pipe_ready),
		.weight_a  (weight_a_q),
		.weight_b  (weight_b_q),
		.pattern_a (phash_a_q),
		.pattern_b (phash_b_q),
		.res       (res),
		.take      (take)
	);

	assign free_out = !out_valid_q || result.ready;
	assign take     = res.valid && free_out;
	assign cnt_new  = (res.match && !(&cnt_q)) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (free_out) out_valid_q <= res.valid;
			if (take) cnt_q <= res.last ? '0 : cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			match_q <= res.match;
			total_q <= TOTAL_W'(cnt_new);
			done_q  <= res.last;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.window_match = match_q;
	assign result.match_total  = total_q;
	assign result.text_done    = done_q;

	`RHSC_ASSERT_IMPLY(a_ready_when_drained, !out_valid_q, text.ready, "input stalled with an empty output register")
	`RHSC_ASSERT_NEXT(a_count_monotonic, take && !res.last, cnt_q >= $past(cnt_q), "match counter decreased within a text")
	`RHSC_ASSERT_ALWAYS(a_seen_bounded, seen_q <= CNT_W'(MAX_PATTERN), "byte count beyond ring depth")
	`RHSC_ASSERT_NEXT(a_text_restart, accept && text.end_of_text, (pos_q == '0) && (seen_q == '0), "ring state not cleared after the last byte")

endmodule

`default_nettype wire
